// ===== hw/rtl/cod_pkg.sv =====
// shared types and constants of the chunk occupancy downsampler
package cod_pkg;

  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 3;
  localparam int SHIFT_W     = 3;
  localparam int COORD_W     = 12;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  localparam logic [SHIFT_W-1:0] MAX_SHIFT = 3'd6;

  localparam logic [CFG_W-1:0]   RESET_DIM   = 13'd1024;
  localparam logic [SHIFT_W-1:0] RESET_SHIFT = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLUME_WIDTH  = 3'd0,
    REG_VOLUME_HEIGHT = 3'd1,
    REG_VOLUME_SLICES = 3'd2,
    REG_CHUNK_SHIFT   = 3'd3
  } cfg_reg_e;

  // per-voxel control bits handed from the position stage to the flag stage
  typedef struct packed {
    logic voxel_set;
    logic first;
    logic last;
    logic in_range;
  } vox_ctl_t;

endpackage

// ===== hw/rtl/chunk_occupancy_downsample.sv =====
// top level: configuration registers, chunk geometry, pipeline and output register
//
// Mask voxels enter one per cycle in raster order (column fastest, then row, then
// slice) and each is ORed into the occupancy flag of its cubic chunk, edge
// 2^chunk_shift. A chunk's coordinates and flag come out on the master stream when
// its last voxel has passed. The block sustains one voxel per clock unless the
// master stream stalls: the flag of one chunk layer sits in a single-port-write,
// registered-read ram of LAYER_CHUNKS entries, and every voxel of a kept chunk does
// one read-modify-write of it, with the write of the previous cycle forwarded. A
// voxel's word passes the position stage, the flag read and the output register
// before it is valid on the master stream. Voxels past the last whole chunk on
// an axis are dropped; a chunk whose layer index does not fit the store sets the
// sticky overflow flag and produces no word. The flag store needs no clearing after
// reset, since the first voxel of each chunk overwrites its entry. Configuration
// writes are always accepted and must only be issued while the block is idle.
module chunk_occupancy_downsample import cod_pkg::*; #(
  parameter int MAX_DIM      = 4096,
  parameter int LAYER_CHUNKS = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // [0] voxel_set
  input  logic                   s_axis_tuser_i,   // [0] volume_start
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,   // chunk_z, chunk_y, chunk_x, occupied
  output logic                   m_axis_tuser_o    // [0] overflow
);

  localparam int POS_W = $clog2(MAX_DIM);
  localparam int EFF_W = $clog2(MAX_DIM+1);
  localparam int CW    = (EFF_W > CFG_W) ? EFF_W : CFG_W;

  logic [CFG_W-1:0]   width_q, height_q, slices_q;
  logic [SHIFT_W-1:0] shift_q;
  logic               cfg_we;

  logic [CW-1:0]      w_eff, h_eff, s_eff, nx, ny, nz;
  logic [SHIFT_W-1:0] shift_eff;

  logic               a_valid, a_ready;
  vox_ctl_t           a_ctl;
  logic [POS_W-1:0]   a_cx, a_cy, a_cz;

  logic               res_valid, res_ready;
  logic [COORD_W-1:0] res_z, res_y, res_x;
  logic               res_occupied, res_overflow;

  logic               out_valid_q;
  logic [COORD_W-1:0] out_z_q, out_y_q, out_x_q;
  logic               out_occupied_q, out_overflow_q;
  logic               out_free;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [CW-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [CW-1:0] vx;
    vx = CW'(v);
    if (vx == '0) begin
      return CW'(1);
    end else if (vx > CW'(MAX_DIM)) begin
      return CW'(MAX_DIM);
    end else begin
      return vx;
    end
  endfunction

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_DIM;
      height_q <= RESET_DIM;
      slices_q <= RESET_DIM;
      shift_q  <= RESET_SHIFT;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_VOLUME_WIDTH:  width_q  <= cfg_data_i;
        REG_VOLUME_HEIGHT: height_q <= cfg_data_i;
        REG_VOLUME_SLICES: slices_q <= cfg_data_i;
        REG_CHUNK_SHIFT:   shift_q  <= cfg_data_i[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff     = eff_dim(width_q);
  assign h_eff     = eff_dim(height_q);
  assign s_eff     = eff_dim(slices_q);
  assign shift_eff = (shift_q > MAX_SHIFT) ? MAX_SHIFT : shift_q;
  assign nx        = w_eff >> shift_eff;
  assign ny        = h_eff >> shift_eff;
  assign nz        = s_eff >> shift_eff;

  cod_pos #(
    .MAX_DIM (MAX_DIM)
  ) u_pos (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .voxel_set_i    (s_axis_tdata_i[0]),
    .volume_start_i (s_axis_tuser_i),
    .w_eff_i        (w_eff),
    .h_eff_i        (h_eff),
    .s_eff_i        (s_eff),
    .nx_i           (nx),
    .ny_i           (ny),
    .nz_i           (nz),
    .shift_i        (shift_eff),
    .a_valid_o      (a_valid),
    .a_ready_i      (a_ready),
    .a_ctl_o        (a_ctl),
    .a_cx_o         (a_cx),
    .a_cy_o         (a_cy),
    .a_cz_o         (a_cz)
  );

  cod_flags #(
    .MAX_DIM      (MAX_DIM),
    .LAYER_CHUNKS (LAYER_CHUNKS)
  ) u_flags (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .a_valid_i      (a_valid),
    .a_ready_o      (a_ready),
    .a_ctl_i        (a_ctl),
    .a_cx_i         (a_cx),
    .a_cy_i         (a_cy),
    .a_cz_i         (a_cz),
    .nx_i           (nx),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_z_o        (res_z),
    .res_y_o        (res_y),
    .res_x_o        (res_x),
    .res_occupied_o (res_occupied),
    .res_overflow_o (res_overflow)
  );

  // output word register
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign res_ready = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      out_z_q        <= res_z;
      out_y_q        <= res_y;
      out_x_q        <= res_x;
      out_occupied_q <= res_occupied;
      out_overflow_q <= res_overflow;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_occupied_q, out_x_q, out_y_q, out_z_q};
  assign m_axis_tuser_o  = out_overflow_q;

endmodule

// ===== hw/rtl/cod_ram.sv =====
// generic single-write, single-read ram with registered read data
module cod_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/cod_pos.sv =====
// raster position counters and chunk coordinate stage
module cod_pos import cod_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                voxel_set_i,
  input  logic                                volume_start_i,
  input  logic [(($clog2(MAX_DIM+1) > CFG_W) ? $clog2(MAX_DIM+1) : CFG_W)-1:0] w_eff_i,
  input  logic [(($clog2(MAX_DIM+1) > CFG_W) ? $clog2(MAX_DIM+1) : CFG_W)-1:0] h_eff_i,
  input  logic [(($clog2(MAX_DIM+1) > CFG_W) ? $clog2(MAX_DIM+1) : CFG_W)-1:0] s_eff_i,
  input  logic [(($clog2(MAX_DIM+1) > CFG_W) ? $clog2(MAX_DIM+1) : CFG_W)-1:0] nx_i,
  input  logic [(($clog2(MAX_DIM+1) > CFG_W) ? $clog2(MAX_DIM+1) : CFG_W)-1:0] ny_i,
  input  logic [(($clog2(MAX_DIM+1) > CFG_W) ? $clog2(MAX_DIM+1) : CFG_W)-1:0] nz_i,
  input  logic [SHIFT_W-1:0]                  shift_i,
  output logic                                a_valid_o,
  input  logic                                a_ready_i,
  output vox_ctl_t                            a_ctl_o,
  output logic [$clog2(MAX_DIM)-1:0]          a_cx_o,
  output logic [$clog2(MAX_DIM)-1:0]          a_cy_o,
  output logic [$clog2(MAX_DIM)-1:0]          a_cz_o
);

  localparam int POS_W = $clog2(MAX_DIM);
  localparam int EFF_W = $clog2(MAX_DIM+1);
  localparam int CW    = (EFF_W > CFG_W) ? EFF_W : CFG_W;

  logic [POS_W-1:0] col_q, row_q, slc_q;
  logic [POS_W-1:0] col_d, row_d, slc_d;
  logic [POS_W-1:0] cur_c, cur_r, cur_s;
  logic [POS_W-1:0] cx, cy, cz, mask;
  logic [CW-1:0]    col_inc, row_inc, slc_inc;
  logic             col_wrap, row_wrap, slc_wrap;
  logic             accept;
  vox_ctl_t         ctl;

  logic             a_valid_q;
  vox_ctl_t         a_ctl_q;
  logic [POS_W-1:0] a_cx_q, a_cy_q, a_cz_q;

  assign in_ready_o = !a_valid_q || a_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // a new volume restarts the raster before this voxel is placed
  assign cur_c = volume_start_i ? '0 : col_q;
  assign cur_r = volume_start_i ? '0 : row_q;
  assign cur_s = volume_start_i ? '0 : slc_q;

  assign cx   = cur_c >> shift_i;
  assign cy   = cur_r >> shift_i;
  assign cz   = cur_s >> shift_i;
  assign mask = ~({POS_W{1'b1}} << shift_i);

  always_comb begin
    ctl.voxel_set = voxel_set_i;
    ctl.first     = ((cur_c & mask) == '0) && ((cur_r & mask) == '0)
                    && ((cur_s & mask) == '0);
    ctl.last      = ((cur_c & mask) == mask) && ((cur_r & mask) == mask)
                    && ((cur_s & mask) == mask);
    ctl.in_range  = (CW'(cx) < nx_i) && (CW'(cy) < ny_i) && (CW'(cz) < nz_i);
  end

  always_comb begin
    col_inc  = CW'(cur_c) + CW'(1);
    row_inc  = CW'(cur_r) + CW'(1);
    slc_inc  = CW'(cur_s) + CW'(1);
    col_wrap = col_inc >= w_eff_i;
    row_wrap = row_inc >= h_eff_i;
    slc_wrap = slc_inc >= s_eff_i;
    col_d    = col_wrap ? '0 : POS_W'(col_inc);
    row_d    = cur_r;
    slc_d    = cur_s;
    if (col_wrap) begin
      row_d = row_wrap ? '0 : POS_W'(row_inc);
      if (row_wrap) begin
        slc_d = slc_wrap ? '0 : POS_W'(slc_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      slc_q     <= '0;
      a_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
        slc_q <= slc_d;
      end
      if (in_ready_o) begin
        a_valid_q <= accept;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_ctl_q <= ctl;
      a_cx_q  <= cx;
      a_cy_q  <= cy;
      a_cz_q  <= cz;
    end
  end

  assign a_valid_o = a_valid_q;
  assign a_ctl_o   = a_ctl_q;
  assign a_cx_o    = a_cx_q;
  assign a_cy_o    = a_cy_q;
  assign a_cz_o    = a_cz_q;

endmodule

// ===== hw/rtl/cod_flags.sv =====
// layer flag store: index compute, read-modify-write with forwarding, result issue
module cod_flags import cod_pkg::*; #(
  parameter int MAX_DIM      = 4096,
  parameter int LAYER_CHUNKS = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                a_valid_i,
  output logic                                a_ready_o,
  input  vox_ctl_t                            a_ctl_i,
  input  logic [$clog2(MAX_DIM)-1:0]          a_cx_i,
  input  logic [$clog2(MAX_DIM)-1:0]          a_cy_i,
  input  logic [$clog2(MAX_DIM)-1:0]          a_cz_i,
  input  logic [(($clog2(MAX_DIM+1) > CFG_W) ? $clog2(MAX_DIM+1) : CFG_W)-1:0] nx_i,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output logic [COORD_W-1:0]                  res_z_o,
  output logic [COORD_W-1:0]                  res_y_o,
  output logic [COORD_W-1:0]                  res_x_o,
  output logic                                res_occupied_o,
  output logic                                res_overflow_o
);

  localparam int POS_W  = $clog2(MAX_DIM);
  localparam int EFF_W  = $clog2(MAX_DIM+1);
  localparam int CW     = (EFF_W > CFG_W) ? EFF_W : CFG_W;
  localparam int PW     = POS_W + CW + 1;
  localparam int ADDR_W = $clog2(LAYER_CHUNKS);

  logic [PW-1:0]     idx_full;
  logic              a_ovf;
  logic [ADDR_W-1:0] a_idx;
  logic              a_move;

  logic                b_valid_q;
  logic [ADDR_W-1:0]   b_idx_q;
  logic                b_bit_q, b_first_q, b_last_q, b_wr_q, b_ovf_q;
  logic [COORD_W-1:0]  b_x_q, b_y_q, b_z_q;
  logic                b_res, b_fire, b_free;

  logic                fw_valid_q;
  logic [ADDR_W-1:0]   fw_addr_q;
  logic                fw_data_q;
  logic                overflow_q;

  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic                rd_data;
  logic                old_flag;
  logic                new_flag;
  logic                we;

  // chunk index within the layer
  assign idx_full = PW'(a_cy_i) * PW'(nx_i) + PW'(a_cx_i);
  assign a_ovf    = idx_full >= PW'(LAYER_CHUNKS);
  assign a_idx    = ADDR_W'(idx_full);

  assign b_res     = b_wr_q && b_last_q;
  assign b_fire    = b_valid_q && (!b_res || res_ready_i);
  assign b_free    = !b_valid_q || b_fire;
  assign a_ready_o = b_free;
  assign a_move    = a_valid_i && b_free;

  // a stalled entry rereads its own flag so the data is current next cycle
  assign rd_addr = a_move ? a_idx : b_idx_q;
  assign rd_en   = a_move || b_valid_q;

  // the write of the previous cycle is not yet in the read data
  assign old_flag = (fw_valid_q && (fw_addr_q == b_idx_q)) ? fw_data_q : rd_data;
  assign new_flag = b_first_q ? b_bit_q : (old_flag | b_bit_q);
  assign we       = b_fire && b_wr_q;

  cod_ram #(
    .WIDTH (1),
    .DEPTH (LAYER_CHUNKS)
  ) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (b_idx_q),
    .wdata_i (new_flag),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q  <= 1'b0;
      fw_valid_q <= 1'b0;
      overflow_q <= 1'b0;
    end else begin
      if (b_free) begin
        b_valid_q <= a_move;
      end
      fw_valid_q <= we;
      if (b_fire && b_ovf_q) begin
        overflow_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      b_idx_q   <= a_idx;
      b_bit_q   <= a_ctl_i.voxel_set;
      b_first_q <= a_ctl_i.first;
      b_last_q  <= a_ctl_i.last;
      b_wr_q    <= a_ctl_i.in_range && !a_ovf;
      b_ovf_q   <= a_ctl_i.in_range && a_ovf;
      b_x_q     <= COORD_W'(a_cx_i);
      b_y_q     <= COORD_W'(a_cy_i);
      b_z_q     <= COORD_W'(a_cz_i);
    end
    if (we) begin
      fw_addr_q <= b_idx_q;
      fw_data_q <= new_flag;
    end
  end

  assign res_valid_o    = b_valid_q && b_res;
  assign res_z_o        = b_z_q;
  assign res_y_o        = b_y_q;
  assign res_x_o        = b_x_q;
  assign res_occupied_o = new_flag;
  assign res_overflow_o = overflow_q;

endmodule
